// File: hdl/rarn_pkg.sv
package rarn_pkg;

    // Row buffer depth default
    localparam int RARN_ROW_LEN = 64;

    // Fixed datapath widths
    localparam int SUM_W  = 37;
    localparam int DIV_W  = 49;
    localparam int MS_W   = 31;
    localparam int ROOT_W = 25;
    localparam int ENTRY_W = 48;

    // Configuration register indexes
    localparam logic [1:0] CFG_EPSILON     = 2'd0;
    localparam logic [1:0] CFG_BIAS_ENABLE = 2'd1;

    typedef struct packed {
        logic signed [15:0] addend_a;
        logic signed [15:0] addend_b;
        logic signed [15:0] gain;
        logic signed [15:0] bias;
        logic               row_end;
    } in_t;

    typedef struct packed {
        logic signed [15:0] normed;
        logic signed [15:0] residual;
        logic [31:0]        inv_rms;
        logic               overflow;
        logic               last_out;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_D1S,
        ST_D1W,
        ST_D2S,
        ST_D2W,
        ST_SQRT,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_OUT
    } state_t;

endpackage

// File: hdl/rarn_ram.sv
module rarn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/rarn_div.sv
module rarn_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rarn_pkg::div_req_t req,
    output rarn_pkg::div_rsp_t rsp
);
    import rarn_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    // One restoring quotient bit per cycle
    always_comb begin
        trial     = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, div_reg}) : trial;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: hdl/residual_add_rms_norm.sv
// Fused residual add and RMS normalization, one row at a time.
// Input channel s_*: one request per row element (two addends, gain, bias,
// row_end). Each element is taken in one cycle while the block is loading.
// The element marked row_end closes the row; the block then stops taking
// requests and computes the row statistics with one shared iterative
// divider (first the mean square, then 2^48 / (mean square + epsilon))
// followed by a 25-step bit-serial root search on one multiplier; the
// second division and root search are skipped when that divisor is zero.
// Results then leave on m_* in load order, one per stored element, each
// passing through a buffer read, two registered multiplies and rounding,
// the next one starting once it is taken; m_valid and m_data hold while
// stalled. After the last result is taken s_ready rises the next cycle.
// Elements past ROW_LEN are dropped and flag overflow on every result.
// Configuration writes (cfg_*) take effect at once and are meant for idle.
// Reset (aresetn low, synchronous) empties the row, sets epsilon to 1 and
// clears bias_enable. The row buffer needs no clearing after reset.
module residual_add_rms_norm #(
    parameter int ROW_LEN = rarn_pkg::RARN_ROW_LEN
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rarn_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rarn_pkg::out_t m_data,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_wdata
);
    import rarn_pkg::*;

    localparam int AW = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
    localparam int CW = $clog2(ROW_LEN + 1);

    state_t state_reg, state_next;

    logic [15:0]       eps_reg;
    logic              bias_en_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]     count_reg;
    logic              dropped_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [DIV_W-1:0]  lim_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        bit_reg;
    logic [31:0]       rstd_reg;
    logic [AW-1:0]     idx_reg;
    logic signed [31:0] rg_reg;
    logic signed [63:0] p_reg;
    logic signed [15:0] res_reg;
    logic signed [15:0] bias_reg;
    logic signed [15:0] res_p_reg;
    logic signed [15:0] bias_p_reg;
    out_t              out_reg;

    logic              in_acc;
    logic              room;
    logic signed [16:0] raw_sum;
    logic signed [15:0] res_sat;
    logic signed [31:0] res_sq;
    logic [MS_W-1:0]   ms_c;
    logic [ROOT_W-1:0] cand;
    logic [2*ROOT_W-1:0] cand_sq;
    logic              is_last;
    logic signed [64:0] p_full;
    logic signed [63:0] p_rnd;
    logic signed [40:0] y_c;
    logic signed [15:0] y_sat;

    logic              ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    div_req_t          dreq;
    div_rsp_t          drsp;

    // Shared divider and row buffer
    rarn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    rarn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROW_LEN)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({res_sat, s_data.gain, s_data.bias}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Load arithmetic
    assign in_acc  = s_valid && s_ready;
    assign room    = count_reg < CW'(ROW_LEN);
    assign raw_sum = 17'(s_data.addend_a) + 17'(s_data.addend_b);
    always_comb begin
        if (raw_sum > 17'sd32767) begin
            res_sat = 16'sh7fff;
        end else if (raw_sum < -17'sd32768) begin
            res_sat = 16'sh8000;
        end else begin
            res_sat = raw_sum[15:0];
        end
    end
    assign res_sq = res_sat * res_sat;

    // Statistics arithmetic
    assign ms_c    = drsp.quotient[MS_W-1:0] + MS_W'(eps_reg);
    assign cand    = root_reg | (ROOT_W'(1) << bit_reg);
    assign cand_sq = cand * cand;
    assign is_last = CW'(idx_reg) == (count_reg - CW'(1));

    // Output arithmetic
    assign p_full = rg_reg * $signed({1'b0, rstd_reg});
    assign p_rnd  = p_reg + 64'sd8388608;
    assign y_c    = 41'($signed(p_rnd[63:24])) +
                    (bias_en_reg ? 41'(bias_p_reg) : 41'sd0);
    always_comb begin
        if (y_c > 41'sd32767) begin
            y_sat = 16'sh7fff;
        end else if (y_c < -41'sd32768) begin
            y_sat = 16'sh8000;
        end else begin
            y_sat = y_c[15:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_data.row_end) state_next = ST_D1S;
            end
            ST_D1S: state_next = ST_D1W;
            ST_D1W: begin
                if (drsp.done) state_next = (ms_c == '0) ? ST_RD : ST_D2S;
            end
            ST_D2S: state_next = ST_D2W;
            ST_D2W: begin
                if (drsp.done) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (bit_reg == 5'd0) state_next = ST_RD;
            end
            ST_RD:  state_next = ST_M1;
            ST_M1:  state_next = ST_M2;
            ST_M2:  state_next = ST_M3;
            ST_M3:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = out_reg.last_out ? ST_LOAD : ST_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        ram_we        = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = DIV_W'(sum_reg);
        dreq.divisor  = DIV_W'(count_reg);
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                ram_we  = in_acc && room;
            end
            ST_D1S: dreq.start = 1'b1;
            ST_D2S: begin
                dreq.start    = 1'b1;
                dreq.dividend = DIV_W'(1) << 48;
                dreq.divisor  = DIV_W'(ms_reg);
            end
            ST_OUT: m_valid = 1'b1;
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            eps_reg     <= 16'd1;
            bias_en_reg <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_index == CFG_EPSILON) eps_reg <= cfg_wdata;
            if (cfg_wr_en && cfg_index == CFG_BIAS_ENABLE) bias_en_reg <= cfg_wdata[0];
            if (in_acc) begin
                if (room) begin
                    sum_reg   <= sum_reg + SUM_W'(unsigned'(res_sq));
                    count_reg <= count_reg + CW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (state_reg == ST_OUT && m_ready && out_reg.last_out) begin
                sum_reg     <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_D1W: begin
                if (drsp.done) begin
                    ms_reg   <= ms_c;
                    rstd_reg <= 32'hffff_ffff;
                    idx_reg  <= '0;
                end
            end
            ST_D2W: begin
                if (drsp.done) begin
                    lim_reg  <= drsp.quotient;
                    root_reg <= '0;
                    bit_reg  <= 5'(ROOT_W - 1);
                end
            end
            ST_SQRT: begin
                if ({1'b0, cand_sq} <= (2*ROOT_W+1)'(lim_reg)) root_reg <= cand;
                bit_reg <= bit_reg - 5'd1;
                if (bit_reg == 5'd0) begin
                    rstd_reg <= 32'({1'b0, root_reg} |
                        ({1'b0, cand_sq} <= (2*ROOT_W+1)'(lim_reg) ? 26'(cand) : 26'd0));
                end
            end
            ST_M1: begin
                rg_reg   <= $signed(ram_rdata[47:32]) * $signed(ram_rdata[31:16]);
                res_reg  <= ram_rdata[47:32];
                bias_reg <= ram_rdata[15:0];
            end
            ST_M2: begin
                p_reg      <= p_full[63:0];
                res_p_reg  <= res_reg;
                bias_p_reg <= bias_reg;
            end
            ST_M3: begin
                out_reg.normed   <= y_sat;
                out_reg.residual <= res_p_reg;
                out_reg.inv_rms  <= rstd_reg;
                out_reg.overflow <= dropped_reg;
                out_reg.last_out <= is_last;
            end
            ST_OUT: begin
                if (m_ready && !out_reg.last_out) idx_reg <= idx_reg + AW'(1);
            end
            default: begin
            end
        endcase
    end

    assign m_data = out_reg;

endmodule

// File: hdl/rarn_checker.sv
module rarn_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input rarn_pkg::out_t m_data
);
    import rarn_pkg::*;

    // Input and output sides never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid high together");

    // A waiting request stays offered
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("request withdrawn before acceptance");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Mid-row result taken: no request accepted next cycle
    a_mid_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_out |=> !s_ready)
        else $error("request taken mid-row");

    // Final result taken: loading resumes
    a_row_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_out |=> s_ready && !m_valid)
        else $error("no return to load after last result");

endmodule

bind residual_add_rms_norm rarn_checker u_rarn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
